>>> rtl/core/rtm_pkg.sv
`default_nettype none

package rtm_pkg;

  localparam int unsigned DEF_MAX_VERTICES = 65536;
  localparam int unsigned DEF_MAX_TEXTURES = 256;
  localparam int unsigned DEF_TRIG_STEPS   = 16;

  // The arctangent table has 32 entries, so the step counter is 5 bits.
  localparam int unsigned TRIG_IDX_W = 5;

  localparam logic [1:0] OP_HEADER   = 2'd0;
  localparam logic [1:0] OP_VERTEX   = 2'd1;
  localparam logic [1:0] OP_TRIANGLE = 2'd2;
  localparam logic [1:0] OP_FINISH   = 2'd3;

  localparam logic [1:0] KIND_VERTEX   = 2'd0;
  localparam logic [1:0] KIND_TRIANGLE = 2'd1;
  localparam logic [1:0] KIND_BOX_MIN  = 2'd2;
  localparam logic [1:0] KIND_BOX_MAX  = 2'd3;

  localparam logic signed [15:0] ONE14     = 16'sd16384;
  localparam logic signed [33:0] GAIN30    = 34'sd652032874;
  localparam logic signed [35:0] HALF_PI30 = 36'sd1686629713;
  localparam logic signed [35:0] PI30      = 36'sd3373259426;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [7:0]         texture;
    logic [31:0]        flags;
    logic               mesh_valid;
    logic               overflow;
    logic               last;
  } res_t;

  function automatic logic [31:0] atan_q30(input logic [TRIG_IDX_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) r = 16'sh7FFF;
    else if (v < -64'sd32768) r = -16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/rigid_transform_mesh_merger.sv
`default_nettype none

// Merges mesh parts into one mesh, one item at a time; the input is stalled while an
// item is in work, and a finished result waits in an output register while the next
// item is taken. A part header runs three CORDIC passes of one micro-rotation a cycle,
// then fifteen steps of the shared 32x16 multiplier build the rotation matrix. A vertex
// makes eighteen passes through that same multiplier and accumulator. A finish
// delivers the box minimum and then the box maximum marked as last and clears the mesh.
module rigid_transform_mesh_merger #(
  parameter int unsigned MAX_VERTICES = rtm_pkg::DEF_MAX_VERTICES,
  parameter int unsigned MAX_TEXTURES = rtm_pkg::DEF_MAX_TEXTURES,
  parameter int unsigned TRIG_STEPS   = rtm_pkg::DEF_TRIG_STEPS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [15:0] norm_x_i,
  input  logic signed [15:0] norm_y_i,
  input  logic signed [15:0] norm_z_i,
  input  logic [15:0]        corner_a_i,
  input  logic [15:0]        corner_b_i,
  input  logic [15:0]        corner_c_i,
  input  logic [7:0]         texture_slot_i,
  input  logic [31:0]        tri_flags_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         result_kind_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic signed [15:0] out_nx_o,
  output logic signed [15:0] out_ny_o,
  output logic signed [15:0] out_nz_o,
  output logic [7:0]         out_texture_o,
  output logic [31:0]        out_flags_o,
  output logic               mesh_valid_o,
  output logic               index_overflow_o,
  output logic               last_o
);

  localparam int unsigned VW  = $clog2(MAX_VERTICES) + 1;
  localparam int unsigned TW  = $clog2(MAX_TEXTURES) + 1;
  localparam int unsigned IW  = ((VW > 16) ? VW : 16) + 1;
  localparam int unsigned TSW = ((TW > 8) ? TW : 8) + 1;
  localparam int unsigned XW  = 34;
  localparam int unsigned ZW  = 36;
  localparam int unsigned SW  = rtm_pkg::TRIG_IDX_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_TINIT = 4'd1;
  localparam logic [3:0] ST_TSTEP = 4'd2;
  localparam logic [3:0] ST_TDONE = 4'd3;
  localparam logic [3:0] ST_MAT   = 4'd4;
  localparam logic [3:0] ST_VTX   = 4'd5;
  localparam logic [3:0] ST_VFIN  = 4'd6;
  localparam logic [3:0] ST_BOX   = 4'd7;
  localparam logic [3:0] ST_EMIT  = 4'd8;
  localparam logic [3:0] ST_FMIN  = 4'd9;
  localparam logic [3:0] ST_FMAX  = 4'd10;

  localparam logic [2:0] MD_NONE = 3'd0;
  localparam logic [2:0] MD_TMP  = 3'd1;
  localparam logic [2:0] MD_LOAD = 3'd2;
  localparam logic [2:0] MD_ADD  = 3'd3;
  localparam logic [2:0] MD_SUB  = 3'd4;

  localparam logic [1:0] WR_NONE = 2'd0;
  localparam logic [1:0] WR_MAT  = 2'd1;
  localparam logic [1:0] WR_POS  = 2'd2;
  localparam logic [1:0] WR_NRM  = 2'd3;

  localparam logic [SW-1:0] MAT_LAST = SW'(14);

  logic [3:0]         state_q, state_d;
  logic [SW-1:0]      uc_q, uc_d;
  logic [1:0]         ai_q, ai_d;
  logic [1:0]         vrow_q, vrow_d;
  logic [2:0]         vcol_q, vcol_d;

  logic signed [15:0] ang_q [3], ang_d [3];
  logic signed [31:0] shift_q [3], shift_d [3];
  logic signed [15:0] m_q [9], m_d [9];
  logic signed [15:0] sin_q [3], sin_d [3];
  logic signed [15:0] cos_q [3], cos_d [3];
  logic signed [XW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [ZW-1:0] cz_q, cz_d;
  logic               neg_q, neg_d;
  logic signed [31:0] vp_q [3], vp_d [3];
  logic signed [15:0] vn_q [3], vn_d [3];
  logic signed [63:0] acc_q, acc_d;
  logic signed [31:0] tmp_q, tmp_d;

  logic [VW-1:0]      vbase_q, vbase_d, pvc_q, pvc_d;
  logic [TW-1:0]      tbase_q, tbase_d;
  logic [7:0]         ptc_q, ptc_d;
  logic signed [31:0] bmin_q [3], bmin_d [3];
  logic signed [31:0] bmax_q [3], bmax_d [3];
  logic               seen_v_q, seen_v_d, seen_t_q, seen_t_d;

  rtm_pkg::res_t      res_q, res_d, out_q, out_d;
  logic               out_valid_q, out_valid_d;

  // Micro-step controls for the shared multiplier.
  logic signed [31:0] mul_a;
  logic signed [15:0] mul_b;
  logic [2:0]         mode;
  logic               shl14;
  logic [1:0]         wr_kind;
  logic [3:0]         wr_idx;
  logic               wr_r28;

  logic signed [47:0] prod;
  logic signed [63:0] addend;
  logic signed [63:0] rv;
  logic signed [63:0] pos_sum;

  logic [1:0]         vj;
  logic [3:0]         midx;
  logic               accept;
  logic               out_free;

  logic signed [ZW-1:0] zi;
  logic signed [ZW-1:0] at;
  logic signed [XW-1:0] xs, ys, xf, yf;
  logic [IW-1:0]      idx_a, idx_b, idx_c;
  logic [TSW-1:0]     tsum_tri, tsum_cmt;
  logic [VW:0]        vsum;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign vj   = (vcol_q < 3'd3) ? vcol_q[1:0] : 2'(vcol_q - 3'd3);
  assign midx = 4'({vrow_q, 1'b0}) + 4'(vrow_q) + 4'(vj);

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mode    = MD_NONE;
    shl14   = 1'b0;
    wr_kind = WR_NONE;
    wr_idx  = '0;
    wr_r28  = 1'b0;
    if (state_q == ST_MAT) begin
      // Angles: a about x, b about y, c about z.
      unique case (uc_q)
        5'd0: begin
          mul_a = 32'(sin_q[0]); mul_b = sin_q[1]; mode = MD_TMP;
        end
        5'd1: begin
          mul_a = 32'(cos_q[1]); mul_b = cos_q[2]; mode = MD_LOAD;
        end
        5'd2: begin
          mul_a = tmp_q; mul_b = cos_q[2]; mode = MD_LOAD;
          wr_kind = WR_MAT; wr_idx = 4'd0;
        end
        5'd3: begin
          mul_a = 32'(cos_q[0]); mul_b = sin_q[2]; mode = MD_SUB; shl14 = 1'b1;
        end
        5'd4: begin
          mul_a = tmp_q; mul_b = sin_q[2]; mode = MD_LOAD;
          wr_kind = WR_MAT; wr_idx = 4'd1; wr_r28 = 1'b1;
        end
        5'd5: begin
          mul_a = 32'(cos_q[0]); mul_b = cos_q[2]; mode = MD_ADD; shl14 = 1'b1;
        end
        5'd6: begin
          mul_a = 32'(cos_q[0]); mul_b = sin_q[1]; mode = MD_TMP;
          wr_kind = WR_MAT; wr_idx = 4'd4; wr_r28 = 1'b1;
        end
        5'd7: begin
          mul_a = tmp_q; mul_b = cos_q[2]; mode = MD_LOAD;
        end
        5'd8: begin
          mul_a = 32'(sin_q[0]); mul_b = sin_q[2]; mode = MD_ADD; shl14 = 1'b1;
        end
        5'd9: begin
          mul_a = tmp_q; mul_b = sin_q[2]; mode = MD_LOAD;
          wr_kind = WR_MAT; wr_idx = 4'd2; wr_r28 = 1'b1;
        end
        5'd10: begin
          mul_a = 32'(sin_q[0]); mul_b = cos_q[2]; mode = MD_SUB; shl14 = 1'b1;
        end
        5'd11: begin
          mul_a = 32'(cos_q[1]); mul_b = sin_q[2]; mode = MD_LOAD;
          wr_kind = WR_MAT; wr_idx = 4'd5; wr_r28 = 1'b1;
        end
        5'd12: begin
          mul_a = 32'(sin_q[0]); mul_b = cos_q[1]; mode = MD_LOAD;
          wr_kind = WR_MAT; wr_idx = 4'd3;
        end
        5'd13: begin
          mul_a = 32'(cos_q[0]); mul_b = cos_q[1]; mode = MD_LOAD;
          wr_kind = WR_MAT; wr_idx = 4'd7;
        end
        5'd14: begin
          wr_kind = WR_MAT; wr_idx = 4'd8;
        end
        default: begin
          mode = MD_NONE;
        end
      endcase
    end else if (state_q == ST_VTX) begin
      mul_a = (vcol_q < 3'd3) ? vp_q[vj] : 32'(vn_q[vj]);
      mul_b = m_q[midx];
      mode  = (vj == 2'd0) ? MD_LOAD : MD_ADD;
      // Each row's sum is written while the next sum is loaded; the last one in ST_VFIN.
      if (vcol_q == 3'd3) begin
        wr_kind = WR_POS; wr_idx = 4'(vrow_q);
      end else if (vcol_q == 3'd0 && vrow_q != 2'd0) begin
        wr_kind = WR_NRM; wr_idx = 4'(2'(vrow_q - 2'd1));
      end
    end else if (state_q == ST_VFIN) begin
      wr_kind = WR_NRM; wr_idx = 4'd2;
    end
  end

  assign prod    = mul_a * mul_b;
  assign addend  = shl14 ? (64'(prod) <<< 14) : 64'(prod);
  assign rv      = wr_r28 ? ((acc_q + 64'sd134217728) >>> 28) : ((acc_q + 64'sd8192) >>> 14);
  assign pos_sum = rv + 64'(shift_q[wr_idx[1:0]]);

  assign zi = ZW'(ang_q[ai_q]) <<< 17;
  assign at = signed'(ZW'(rtm_pkg::atan_q30(uc_q)));
  assign xs = cx_q >>> uc_q;
  assign ys = cy_q >>> uc_q;
  assign xf = neg_q ? -cx_q : cx_q;
  assign yf = neg_q ? -cy_q : cy_q;

  assign idx_a    = IW'(corner_a_i) + IW'(vbase_q);
  assign idx_b    = IW'(corner_b_i) + IW'(vbase_q);
  assign idx_c    = IW'(corner_c_i) + IW'(vbase_q);
  assign tsum_tri = TSW'(texture_slot_i) + TSW'(tbase_q);
  assign tsum_cmt = TSW'(ptc_q) + TSW'(tbase_q);
  assign vsum     = (VW+1)'(vbase_q) + (VW+1)'(pvc_q);

  always_comb begin
    state_d     = state_q;
    uc_d        = uc_q;
    ai_d        = ai_q;
    vrow_d      = vrow_q;
    vcol_d      = vcol_q;
    ang_d       = ang_q;
    shift_d     = shift_q;
    m_d         = m_q;
    sin_d       = sin_q;
    cos_d       = cos_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cz_d        = cz_q;
    neg_d       = neg_q;
    vp_d        = vp_q;
    vn_d        = vn_q;
    acc_d       = acc_q;
    tmp_d       = tmp_q;
    vbase_d     = vbase_q;
    pvc_d       = pvc_q;
    tbase_d     = tbase_q;
    ptc_d       = ptc_q;
    bmin_d      = bmin_q;
    bmax_d      = bmax_q;
    seen_v_d    = seen_v_q;
    seen_t_d    = seen_t_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (mode)
      MD_TMP:  tmp_d = prod[31:0];
      MD_LOAD: acc_d = addend;
      MD_ADD:  acc_d = acc_q + addend;
      MD_SUB:  acc_d = acc_q - addend;
      default: acc_d = acc_q;
    endcase

    case (wr_kind)
      WR_MAT: m_d[wr_idx] = rtm_pkg::sat16(rv);
      WR_POS: begin
        case (wr_idx[1:0])
          2'd0:    res_d.x = rtm_pkg::sat32(pos_sum);
          2'd1:    res_d.y = rtm_pkg::sat32(pos_sum);
          default: res_d.z = rtm_pkg::sat32(pos_sum);
        endcase
      end
      WR_NRM: begin
        case (wr_idx[1:0])
          2'd0:    res_d.nx = rtm_pkg::sat16(rv);
          2'd1:    res_d.ny = rtm_pkg::sat16(rv);
          default: res_d.nz = rtm_pkg::sat16(rv);
        endcase
      end
      default: ;
    endcase

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (operation_i)
            rtm_pkg::OP_HEADER: begin
              // Fold the previous part into the bases only if it had vertices.
              if (pvc_q != '0) begin
                vbase_d = (vsum > (VW+1)'(MAX_VERTICES)) ? VW'(MAX_VERTICES) : vsum[VW-1:0];
                tbase_d = (tsum_cmt > TSW'(MAX_TEXTURES)) ? TW'(MAX_TEXTURES)
                                                          : tsum_cmt[TW-1:0];
              end
              pvc_d      = '0;
              ptc_d      = texture_slot_i;
              shift_d[0] = pos_x_i;
              shift_d[1] = pos_y_i;
              shift_d[2] = pos_z_i;
              ang_d[0]   = norm_x_i;
              ang_d[1]   = norm_y_i;
              ang_d[2]   = norm_z_i;
              ai_d       = 2'd0;
              state_d    = ST_TINIT;
            end
            rtm_pkg::OP_VERTEX: begin
              vp_d[0] = pos_x_i;
              vp_d[1] = pos_y_i;
              vp_d[2] = pos_z_i;
              vn_d[0] = norm_x_i;
              vn_d[1] = norm_y_i;
              vn_d[2] = norm_z_i;
              res_d      = '0;
              res_d.kind = rtm_pkg::KIND_VERTEX;
              vrow_d     = 2'd0;
              vcol_d     = 3'd0;
              state_d    = ST_VTX;
            end
            rtm_pkg::OP_TRIANGLE: begin
              // A triangle ahead of its part's first vertex is dropped.
              if (pvc_q != '0) begin
                res_d          = '0;
                res_d.kind     = rtm_pkg::KIND_TRIANGLE;
                res_d.x        = signed'(32'(idx_a));
                res_d.y        = signed'(32'(idx_b));
                res_d.z        = signed'(32'(idx_c));
                res_d.texture  = tsum_tri[7:0];
                res_d.flags    = tri_flags_i;
                res_d.overflow = (idx_a >= IW'(MAX_VERTICES)) ||
                                 (idx_b >= IW'(MAX_VERTICES)) ||
                                 (idx_c >= IW'(MAX_VERTICES)) ||
                                 (tsum_tri >= TSW'(MAX_TEXTURES)) ||
                                 (tsum_tri > TSW'(255));
                seen_t_d = 1'b1;
                state_d  = ST_EMIT;
              end
            end
            default: begin
              state_d = ST_FMIN;
            end
          endcase
        end
      end
      ST_TINIT: begin
        neg_d = 1'b0;
        cz_d  = zi;
        if (zi > rtm_pkg::HALF_PI30) begin
          cz_d  = zi - rtm_pkg::PI30;
          neg_d = 1'b1;
        end else if (zi < -rtm_pkg::HALF_PI30) begin
          cz_d  = zi + rtm_pkg::PI30;
          neg_d = 1'b1;
        end
        cx_d    = XW'(rtm_pkg::GAIN30);
        cy_d    = '0;
        uc_d    = '0;
        state_d = ST_TSTEP;
      end
      ST_TSTEP: begin
        if (cz_q >= 0) begin
          cx_d = cx_q - ys;
          cy_d = cy_q + xs;
          cz_d = cz_q - at;
        end else begin
          cx_d = cx_q + ys;
          cy_d = cy_q - xs;
          cz_d = cz_q + at;
        end
        if (uc_q == SW'(TRIG_STEPS - 1)) begin
          state_d = ST_TDONE;
        end else begin
          uc_d = uc_q + 1'b1;
        end
      end
      ST_TDONE: begin
        cos_d[ai_q] = rtm_pkg::sat16((64'(xf) + 64'sd32768) >>> 16);
        sin_d[ai_q] = rtm_pkg::sat16((64'(yf) + 64'sd32768) >>> 16);
        if (ai_q == 2'd2) begin
          uc_d    = '0;
          state_d = ST_MAT;
        end else begin
          ai_d    = ai_q + 1'b1;
          state_d = ST_TINIT;
        end
      end
      ST_MAT: begin
        if (uc_q == MAT_LAST) begin
          m_d[6]  = rtm_pkg::sat16(-64'(sin_q[1]));
          state_d = ST_IDLE;
        end else begin
          uc_d = uc_q + 1'b1;
        end
      end
      ST_VTX: begin
        if (vcol_q == 3'd5) begin
          vcol_d = 3'd0;
          vrow_d = vrow_q + 1'b1;
          if (vrow_q == 2'd2) begin
            state_d = ST_VFIN;
          end
        end else begin
          vcol_d = vcol_q + 1'b1;
        end
      end
      ST_VFIN: begin
        state_d = ST_BOX;
      end
      ST_BOX: begin
        if (res_q.x < bmin_q[0]) bmin_d[0] = res_q.x;
        if (res_q.y < bmin_q[1]) bmin_d[1] = res_q.y;
        if (res_q.z < bmin_q[2]) bmin_d[2] = res_q.z;
        if (res_q.x > bmax_q[0]) bmax_d[0] = res_q.x;
        if (res_q.y > bmax_q[1]) bmax_d[1] = res_q.y;
        if (res_q.z > bmax_q[2]) bmax_d[2] = res_q.z;
        if (pvc_q < VW'(MAX_VERTICES)) pvc_d = pvc_q + 1'b1;
        seen_v_d = 1'b1;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_FMIN: begin
        if (out_free) begin
          out_d            = '0;
          out_d.kind       = rtm_pkg::KIND_BOX_MIN;
          out_d.x          = bmin_q[0];
          out_d.y          = bmin_q[1];
          out_d.z          = bmin_q[2];
          out_d.mesh_valid = seen_v_q && seen_t_q;
          out_valid_d      = 1'b1;
          state_d          = ST_FMAX;
        end
      end
      ST_FMAX: begin
        if (out_free) begin
          out_d            = '0;
          out_d.kind       = rtm_pkg::KIND_BOX_MAX;
          out_d.x          = bmax_q[0];
          out_d.y          = bmax_q[1];
          out_d.z          = bmax_q[2];
          out_d.mesh_valid = seen_v_q && seen_t_q;
          out_d.last       = 1'b1;
          out_valid_d      = 1'b1;
          // The mesh starts afresh after its box has been sent.
          for (int k = 0; k < 9; k++) begin
            m_d[k] = (k % 4 == 0) ? rtm_pkg::ONE14 : 16'sd0;
          end
          for (int k = 0; k < 3; k++) begin
            shift_d[k] = '0;
            bmin_d[k]  = 32'sh7FFFFFFF;
            bmax_d[k]  = 32'sh80000000;
          end
          vbase_d  = '0;
          pvc_d    = '0;
          tbase_d  = '0;
          ptc_d    = '0;
          seen_v_d = 1'b0;
          seen_t_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      uc_q        <= '0;
      ai_q        <= '0;
      vrow_q      <= '0;
      vcol_q      <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        m_q[k] <= (k % 4 == 0) ? rtm_pkg::ONE14 : 16'sd0;
      end
      for (int k = 0; k < 3; k++) begin
        shift_q[k] <= '0;
        bmin_q[k]  <= 32'sh7FFFFFFF;
        bmax_q[k]  <= 32'sh80000000;
      end
      vbase_q  <= '0;
      pvc_q    <= '0;
      tbase_q  <= '0;
      ptc_q    <= '0;
      seen_v_q <= 1'b0;
      seen_t_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      uc_q        <= uc_d;
      ai_q        <= ai_d;
      vrow_q      <= vrow_d;
      vcol_q      <= vcol_d;
      out_valid_q <= out_valid_d;
      m_q         <= m_d;
      shift_q     <= shift_d;
      bmin_q      <= bmin_d;
      bmax_q      <= bmax_d;
      vbase_q     <= vbase_d;
      pvc_q       <= pvc_d;
      tbase_q     <= tbase_d;
      ptc_q       <= ptc_d;
      seen_v_q    <= seen_v_d;
      seen_t_q    <= seen_t_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q <= ang_d;
    sin_q <= sin_d;
    cos_q <= cos_d;
    cx_q  <= cx_d;
    cy_q  <= cy_d;
    cz_q  <= cz_d;
    neg_q <= neg_d;
    vp_q  <= vp_d;
    vn_q  <= vn_d;
    acc_q <= acc_d;
    tmp_q <= tmp_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = out_q.kind;
  assign out_x_o          = out_q.x;
  assign out_y_o          = out_q.y;
  assign out_z_o          = out_q.z;
  assign out_nx_o         = out_q.nx;
  assign out_ny_o         = out_q.ny;
  assign out_nz_o         = out_q.nz;
  assign out_texture_o    = out_q.texture;
  assign out_flags_o      = out_q.flags;
  assign mesh_valid_o     = out_q.mesh_valid;
  assign index_overflow_o = out_q.overflow;
  assign last_o           = out_q.last;

endmodule

`default_nettype wire
